// ===== src/odd_even_transposition_sorter_defines.svh =====
// Assertion helpers used by the sorter top module.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH

// Checked on every rising edge of clk while arst_n is released.
`define OETS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising edge of clk, reset or not.
`define OETS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/oets_pkg.sv =====
package oets_pkg;

	localparam int OETS_MAX_ITEMS = 64;
	localparam int OETS_DATA_W = 32;

	// One slot of the sorting row. An empty slot ranks above every held word.
	typedef struct packed {
		logic valid;
		logic [OETS_DATA_W-1:0] value;
	} elem_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SORT_EVEN,
		CELL_SORT_ODD,
		CELL_EMIT
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	function automatic logic elem_greater(input elem_t a, input elem_t b);
		logic res;
		res = (!a.valid && b.valid) ||
			(a.valid && b.valid && ($signed(a.value) > $signed(b.value)));
		return res;
	endfunction

endpackage

// ===== src/odd_even_transposition_sorter.sv =====
// Collects signed 32-bit words, one per start pulse, until a word marked is_last,
// then returns them in ascending order on sorted_value with result_strobe high for
// one cycle each; is_final marks the last one and overflowed is set on every result
// of a batch that had words dropped for lack of room (MAX_ITEMS words are held).
// After the last word busy rises: the held words are then sorted, one compare-exchange
// phase of the cell row per cycle, and afterwards returned in back-to-back result
// cycles. Results cannot be stalled; the receiver must take each one as it
// appears. busy falls in the cycle after the final result.
`include "odd_even_transposition_sorter_defines.svh"

module odd_even_transposition_sorter
	import oets_pkg::*;
#(
	parameter int MAX_ITEMS = OETS_MAX_ITEMS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [OETS_DATA_W-1:0] value,
	input  logic                   is_last,
	output logic                   result_strobe,
	output logic [OETS_DATA_W-1:0] sorted_value,
	output logic                   is_final,
	output logic                   overflowed
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] phase_q, phase_d;
	logic ovf_q, ovf_d;
	cell_mode_t mode;

	elem_t cells [MAX_ITEMS];
	elem_t left_nb [MAX_ITEMS];
	elem_t right_nb [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] valid_vec;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_row
			if (gi == 0) begin : g_first
				// During sorting the word below the row must never win a compare.
				always_comb begin
					if (state_q == ST_SORT) begin
						left_nb[gi].valid = 1'b1;
						left_nb[gi].value = {1'b1, {(OETS_DATA_W-1){1'b0}}};
					end else begin
						left_nb[gi].valid = 1'b1;
						left_nb[gi].value = value;
					end
				end
			end else begin : g_inner_l
				assign left_nb[gi] = cells[gi-1];
			end
			if (gi == MAX_ITEMS - 1) begin : g_last
				assign right_nb[gi] = '{valid: 1'b0, value: '0};
			end else begin : g_inner_r
				assign right_nb[gi] = cells[gi+1];
			end

			oets_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.mode    (mode),
				.odd_pos (1'(gi % 2)),
				.left    (left_nb[gi]),
				.right   (right_nb[gi]),
				.cur     (cells[gi])
			);

			assign valid_vec[gi] = cells[gi].valid;
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		phase_d = phase_q;
		ovf_d   = ovf_q;
		mode    = CELL_HOLD;
		unique case (state_q)
			ST_LOAD: begin
				if (start) begin
					if (count_q < CW'(MAX_ITEMS)) begin
						mode    = CELL_LOAD;
						count_d = count_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (is_last) begin
						state_d = ST_SORT;
						phase_d = '0;
					end
				end
			end
			ST_SORT: begin
				mode    = phase_q[0] ? CELL_SORT_ODD : CELL_SORT_EVEN;
				phase_d = phase_q + CW'(1);
				if (phase_q == count_q - CW'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				mode    = CELL_EMIT;
				count_d = count_q - CW'(1);
				if (count_q == CW'(1)) begin
					state_d = ST_LOAD;
					ovf_d   = 1'b0;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			phase_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			phase_q <= phase_d;
			ovf_q   <= ovf_d;
		end
	end

	assign busy          = (state_q != ST_LOAD);
	assign result_strobe = (state_q == ST_EMIT);
	assign sorted_value  = cells[0].value;
	assign is_final      = (state_q == ST_EMIT) && (count_q == CW'(1));
	assign overflowed    = ovf_q;

	`OETS_ASSERT_ALWAYS(a_strobe_busy, result_strobe |-> busy, "result word while idle")
	`OETS_ASSERT(a_count_match, $countones(valid_vec) == 32'(count_q), "cell fill mismatch")
	`OETS_ASSERT(a_last_starts, (start && !busy && is_last) |=> busy, "batch end not taken")
	`OETS_ASSERT(a_burst, (result_strobe && !is_final) |=> result_strobe, "result burst broken")
	`OETS_ASSERT(a_emit_valid, result_strobe |-> cells[0].valid, "empty slot emitted")
	`OETS_ASSERT(a_idle_end, $fell(busy) |-> $past(result_strobe && is_final), "early idle")

endmodule

// ===== src/oets_cell.sv =====
module oets_cell
	import oets_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_mode_t mode,
	input  logic       odd_pos,
	input  elem_t      left,
	input  elem_t      right,
	output elem_t      cur
);

	logic valid_q;
	logic [OETS_DATA_W-1:0] value_q;
	elem_t cur_d;

	assign cur = '{valid: valid_q, value: value_q};

	always_comb begin
		cur_d = cur;
		case (mode) inside
			CELL_LOAD: cur_d = left;
			CELL_EMIT: cur_d = right;
			CELL_SORT_EVEN, CELL_SORT_ODD: begin
				// The cell is the lower member of its pair when its position parity
				// matches the phase, and then keeps the smaller of the two words.
				if (odd_pos == (mode == CELL_SORT_ODD)) begin
					if (elem_greater(cur, right)) begin
						cur_d = right;
					end
				end else begin
					if (elem_greater(left, cur)) begin
						cur_d = left;
					end
				end
			end
			default: cur_d = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cur_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= cur_d.value;
	end

endmodule
